/* sv/ball_feed_sequencer_core_assert.svh */
// Assertion macros for the ball feed sequencer.
// Used by files that hold clk and arst_n in scope; no other dependencies.
`ifndef BALL_FEED_SEQUENCER_CORE_ASSERT_SVH
`define BALL_FEED_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/bfs_pkg.sv */
// Types and constants of the ball feed sequencer.
// No dependencies; imported by bfs_in_if, bfs_cfg_if and all modules.
`default_nettype none

package bfs_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned TMO_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		CMD_STEP    = 2'd0,
		CMD_REQUEST = 2'd1,
		CMD_RESET   = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_WAIT_TUBE    = 3'd1,
		PH_READY        = 3'd2,
		PH_ACTUATING    = 3'd3,
		PH_WAIT_CHAMBER = 3'd4,
		PH_SHOT_EXIT    = 3'd5,
		PH_RELOAD       = 3'd6,
		PH_JAM          = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_NO_BALL = 2'd1,
		CAUSE_CHAMBER = 2'd2,
		CAUSE_EXIT    = 2'd3
	} cause_t;

	// Host fault kind
	localparam logic HOST_JAM     = 1'b0;
	localparam logic HOST_NO_BALL = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHAMBER_TMO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_TMO    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELOAD_DLY  = 2'd2;

	// Register reset values
	localparam logic [TMO_W-1:0] CHAMBER_TMO_RST = 16'd1000;
	localparam logic [TMO_W-1:0] EXIT_TMO_RST    = 16'd1000;
	localparam logic [TMO_W-1:0] RELOAD_DLY_RST  = 16'd500;

	typedef struct packed {
		cmd_t              cmd;
		logic              tube_ball;
		logic              chamber_ready;
		logic              exit_seen;
		logic [TIME_W-1:0] now_ms;
	} bfs_item_t;

	typedef struct packed {
		phase_t            phase;
		logic [TIME_W-1:0] enter_time;
		logic              jam_flag;
		cause_t            jam_cause;
		logic              tube_seen;
	} bfs_state_t;

	typedef struct packed {
		logic [TMO_W-1:0] chamber_timeout_ms;
		logic [TMO_W-1:0] exit_timeout_ms;
		logic [TMO_W-1:0] reload_pause_ms;
	} bfs_cfg_t;

	typedef struct packed {
		phase_t feed_phase;
		logic   is_ready;
		logic   fault_flag;
		cause_t fault_cause;
		logic   feed_pulse;
		logic   fault_raised;
		logic   host_fault_kind;
	} bfs_result_t;

endpackage

`default_nettype wire

/* sv/bfs_if.sv */
// Channel interfaces of the ball feed sequencer: item in, result out, register write.
// Depends on bfs_pkg for field widths.
`default_nettype none

interface bfs_in_if import bfs_pkg::*;;
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic              tube_ball;
	logic              chamber_ready;
	logic              exit_seen;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, cmd, tube_ball, chamber_ready, exit_seen, now_ms,
		input ready);
	modport sink (input valid, cmd, tube_ball, chamber_ready, exit_seen, now_ms,
		output ready);
endinterface

interface bfs_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] feed_phase;
	logic       is_ready;
	logic       fault_flag;
	logic [1:0] fault_cause;
	logic       feed_pulse;
	logic       fault_raised;
	logic       host_fault_kind;

	modport source (output valid, feed_phase, is_ready, fault_flag, fault_cause,
		feed_pulse, fault_raised, host_fault_kind, input ready);
	modport sink (input valid, feed_phase, is_ready, fault_flag, fault_cause,
		feed_pulse, fault_raised, host_fault_kind, output ready);
endinterface

interface bfs_cfg_if import bfs_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [TMO_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/bfs_step.sv */
// Phase machine of the feeder: next state and result for one item.
// Pure combinational; depends on bfs_pkg.
`default_nettype none

module bfs_step import bfs_pkg::*; (
	input  bfs_item_t   item,
	input  bfs_state_t  state,
	input  bfs_cfg_t    cfg,
	output bfs_state_t  next_state,
	output bfs_result_t result
);

	logic [TIME_W-1:0] elapsed;
	logic [TMO_W-1:0]  limit;
	logic              over_limit;
	logic              pulse;
	logic              raised;
	logic              raised_kind;

	// Time in phase, with wrap; pick the limit of the current phase
	assign elapsed = item.now_ms - state.enter_time;

	always_comb begin
		case (state.phase)
			PH_WAIT_CHAMBER: limit = cfg.chamber_timeout_ms;
			PH_SHOT_EXIT:    limit = cfg.exit_timeout_ms;
			default:         limit = cfg.reload_pause_ms;
		endcase
	end

	assign over_limit = elapsed > {{(TIME_W-TMO_W){1'b0}}, limit};

	// Next state
	always_comb begin
		next_state = state;
		case (item.cmd)
			CMD_STEP: begin
				next_state.tube_seen = item.tube_ball;
				case (state.phase)
					PH_IDLE: begin
						next_state.phase      = item.tube_ball ? PH_READY : PH_WAIT_TUBE;
						next_state.enter_time = item.now_ms;
					end
					PH_WAIT_TUBE: begin
						if (item.tube_ball) begin
							next_state.phase      = PH_READY;
							next_state.enter_time = item.now_ms;
						end
					end
					PH_READY: begin
						if (!item.tube_ball) begin
							next_state.phase      = PH_WAIT_TUBE;
							next_state.enter_time = item.now_ms;
						end
					end
					PH_ACTUATING: begin
						next_state.phase      = PH_WAIT_CHAMBER;
						next_state.enter_time = item.now_ms;
					end
					PH_WAIT_CHAMBER: begin
						if (item.chamber_ready) begin
							next_state.phase      = PH_SHOT_EXIT;
							next_state.enter_time = item.now_ms;
						end else if (over_limit) begin
							next_state.phase      = PH_JAM;
							next_state.enter_time = item.now_ms;
							next_state.jam_flag   = 1'b1;
							next_state.jam_cause  = CAUSE_CHAMBER;
						end
					end
					PH_SHOT_EXIT: begin
						if (item.exit_seen) begin
							next_state.phase      = PH_RELOAD;
							next_state.enter_time = item.now_ms;
						end else if (over_limit) begin
							next_state.phase      = PH_JAM;
							next_state.enter_time = item.now_ms;
							next_state.jam_flag   = 1'b1;
							next_state.jam_cause  = CAUSE_EXIT;
						end
					end
					PH_RELOAD: begin
						if (over_limit) begin
							next_state.phase      = PH_WAIT_TUBE;
							next_state.enter_time = item.now_ms;
						end
					end
					default: begin
						// jam holds until a reset command
					end
				endcase
			end
			CMD_REQUEST: begin
				if (!state.tube_seen) begin
					next_state.phase      = PH_JAM;
					next_state.enter_time = item.now_ms;
					next_state.jam_flag   = 1'b1;
					next_state.jam_cause  = CAUSE_NO_BALL;
				end else if (state.phase == PH_READY) begin
					next_state.phase      = PH_WAIT_CHAMBER;
					next_state.enter_time = item.now_ms;
				end
			end
			CMD_RESET: begin
				// tube sample is kept
				next_state.phase      = PH_IDLE;
				next_state.enter_time = item.now_ms;
				next_state.jam_flag   = 1'b0;
				next_state.jam_cause  = CAUSE_NONE;
			end
			default: begin
				// no operation
			end
		endcase
	end

	// Event outputs: actuator pulse and host fault
	always_comb begin
		pulse       = 1'b0;
		raised      = 1'b0;
		raised_kind = HOST_JAM;
		case (item.cmd)
			CMD_STEP: begin
				if ((state.phase == PH_WAIT_CHAMBER && !item.chamber_ready && over_limit) ||
					(state.phase == PH_SHOT_EXIT && !item.exit_seen && over_limit)) begin
					raised = 1'b1;
				end
			end
			CMD_REQUEST: begin
				if (!state.tube_seen) begin
					raised      = 1'b1;
					raised_kind = HOST_NO_BALL;
				end else if (state.phase == PH_READY) begin
					pulse = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Status after the item
	always_comb begin
		result.feed_phase      = next_state.phase;
		result.is_ready        = (next_state.phase == PH_READY);
		result.fault_flag      = next_state.jam_flag;
		result.fault_cause     = next_state.jam_cause;
		result.feed_pulse      = pulse;
		result.fault_raised    = raised;
		result.host_fault_kind = raised_kind;
	end

endmodule

`default_nettype wire

/* sv/ball_feed_sequencer_core.sv */
// Ball feed sequencer top level: input register, phase machine, result register.
// Depends on bfs_pkg, bfs_if (channel interfaces), bfs_step and the assertion macros.
//
//  channel   dir  handshake     payload
//  feed_in   in   valid/ready   cmd, tube_ball, chamber_ready, exit_seen, now_ms
//  feed_out  out  valid/ready   feed_phase, is_ready, fault_flag, fault_cause,
//                               feed_pulse, fault_raised, host_fault_kind
//  cfg       in   valid/ready   index, data (always ready)
//
// One item per cycle sustained while feed_out is ready; an input transfer loads the input
// register, then the item passes to the result register, from which the result transfers.
// The rate is set by the phase register loop: each item reads it and updates it in turn.
// Reset brings the phase to idle, clears the fault and loads register defaults.
// A stalled result holds the result register; an empty input register still takes one
// item while the result waits, then input ready stays low until the result is taken.
`default_nettype none

module ball_feed_sequencer_core import bfs_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	bfs_in_if.sink     feed_in,
	bfs_out_if.source  feed_out,
	bfs_cfg_if.sink    cfg
);

`include "ball_feed_sequencer_core_assert.svh"

	bfs_cfg_t    cfg_q;
	bfs_state_t  state_q;
	bfs_state_t  next_state;
	bfs_item_t   item_s1;
	logic        vld_s1;
	bfs_result_t res_s2;
	bfs_result_t res_next;
	logic        vld_s2;
	logic        adv;
	logic        in_ready;

	// Register writes; indexes beyond the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chamber_timeout_ms <= CHAMBER_TMO_RST;
			cfg_q.exit_timeout_ms    <= EXIT_TMO_RST;
			cfg_q.reload_pause_ms    <= RELOAD_DLY_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CHAMBER_TMO: cfg_q.chamber_timeout_ms <= cfg.data;
				REG_EXIT_TMO:    cfg_q.exit_timeout_ms    <= cfg.data;
				REG_RELOAD_DLY:  cfg_q.reload_pause_ms    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Advance when the result register is free or being drained
	assign adv             = !vld_s2 || feed_out.ready;
	assign in_ready        = !vld_s1 || adv;
	assign feed_in.ready   = in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= feed_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && feed_in.valid) begin
			item_s1.cmd           <= cmd_t'(feed_in.cmd);
			item_s1.tube_ball     <= feed_in.tube_ball;
			item_s1.chamber_ready <= feed_in.chamber_ready;
			item_s1.exit_seen     <= feed_in.exit_seen;
			item_s1.now_ms        <= feed_in.now_ms;
		end
	end

	bfs_step u_step (
		.item       (item_s1),
		.state      (state_q),
		.cfg        (cfg_q),
		.next_state (next_state),
		.result     (res_next)
	);

	// Commit the item: update state, load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_IDLE;
			state_q.enter_time <= '0;
			state_q.jam_flag   <= 1'b0;
			state_q.jam_cause  <= CAUSE_NONE;
			state_q.tube_seen  <= 1'b0;
			vld_s2             <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				state_q <= next_state;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			res_s2 <= res_next;
		end
	end

	// Drive the result channel
	assign feed_out.valid           = vld_s2;
	assign feed_out.feed_phase      = res_s2.feed_phase;
	assign feed_out.is_ready        = res_s2.is_ready;
	assign feed_out.fault_flag      = res_s2.fault_flag;
	assign feed_out.fault_cause     = res_s2.fault_cause;
	assign feed_out.feed_pulse      = res_s2.feed_pulse;
	assign feed_out.fault_raised    = res_s2.fault_raised;
	assign feed_out.host_fault_kind = res_s2.host_fault_kind;

	// Checks
	`BFS_ASSERT_NXT(a_state_hold, !(adv && vld_s1), $stable(state_q), "state moved without an item")
	`BFS_ASSERT_NXT(a_s1_hold, vld_s1 && !adv, vld_s1, "stalled item dropped from input register")
	`BFS_ASSERT_IMP(a_cause_flag, 1'b1, state_q.jam_flag == (state_q.jam_cause != CAUSE_NONE), "fault flag and cause disagree")
	`BFS_ASSERT_IMP(a_raise_jam, vld_s2 && res_s2.fault_raised, res_s2.fault_flag && (res_s2.feed_phase == PH_JAM), "fault raised outside jam")
	`BFS_ASSERT_IMP(a_pulse_wait, vld_s2 && res_s2.feed_pulse, (res_s2.feed_phase == PH_WAIT_CHAMBER) && !res_s2.fault_raised, "feed pulse without chamber wait")

endmodule

`default_nettype wire
